// ===== hw/rtl/mcbf_pkg.sv =====
// shared types, constants and codes for the multi-channel fifo
package mcbf_pkg;

    localparam int MaxChannels = 8;
    localparam int QueueDepth  = 16;
    localparam int ChW   = $clog2(MaxChannels);
    localparam int PosW  = $clog2(QueueDepth);
    localparam int CntW  = $clog2(QueueDepth + 1);
    localparam int WordAddrW = ChW + PosW;
    localparam int WordDepth = MaxChannels * QueueDepth;
    // open, limit, count, head
    localparam int SlotW = 1 + CntW + CntW + PosW;

    typedef enum logic [2:0] {
        ACT_OPEN      = 3'd0,
        ACT_CLOSE     = 3'd1,
        ACT_SEND      = 3'd2,
        ACT_RECV      = 3'd3,
        ACT_BROADCAST = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NO_CHANNEL   = 2'd1,
        ST_WOULD_BLOCK  = 2'd2,
        ST_NO_FREE_SLOT = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  channel;
        logic [31:0] data_in;
        logic [31:0] req_limit;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  opened_channel;
        logic [31:0] data_out;
    } t_out_item;

    typedef struct packed {
        logic            open;
        logic [CntW-1:0] limit;
        logic [CntW-1:0] count;
        logic [PosW-1:0] head;
    } t_slot;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_BC_READ,
        S_BC_CHECK,
        S_BC_WRITE,
        S_DONE
    } t_state;

endpackage

// ===== hw/rtl/mcbf_ram.sv =====
// generic single-port-write, registered-read ram
module mcbf_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/multi_channel_bounded_fifo.sv =====
// top level: bounded multi-channel fifo mailbox
//
// input channel: i_in_valid / o_in_stall carry one request item (action,
// channel, data word, requested limit). output channel: o_out_valid /
// i_out_stall carry one result item (status, opened channel, received word).
// every request gives exactly one result; one item is handled at a time.
// slot state (open flag, limit, count, head) sits in a small memory, and the
// queued words in a second memory; both have a registered read port.
// open flags are mirrored in flip-flops so open can find the lowest free slot.
// open, close, send: slot read on accept, then write back and result registered
// in exec; recv on an open channel adds the word read, which lands in done.
// broadcast walks every slot through the single slot memory read port: a check
// pass, then a write pass when some slot is open and no open slot is full; the
// result comes at the end of the check pass when it fails, else after the writes.
// the result sits in an output register and o_in_stall stays high while it
// waits, so with no receiver stall the input opens once the output register
// empties; a stalled receiver holds the result and blocks the input.
// reset (synchronous, active low) clears flags, control state and slot
// memory by a clearing pass over every slot during which no item is
// accepted.
module multi_channel_bounded_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mcbf_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mcbf_pkg::t_out_item o_out_item
);
    import mcbf_pkg::*;

    t_state r_state, n_state;
    t_in_item r_req;
    logic [MaxChannels-1:0] r_open;
    logic [ChW:0] r_idx, n_idx;        // walk / clear index
    logic r_clear, n_clear;
    logic r_full_seen, n_full_seen;
    t_out_item r_out, n_out;
    logic r_out_valid, n_out_valid;

    // slot memory ports
    logic          slot_we;
    logic [ChW-1:0] slot_waddr, slot_raddr;
    t_slot         slot_wdata, slot_rdata;
    // word memory ports
    logic                 word_we;
    logic [WordAddrW-1:0] word_waddr, word_raddr;
    logic [31:0]          word_wdata, word_rdata;

    mcbf_ram #(.Width(SlotW), .Depth(MaxChannels)) u_slot_ram (
        .i_clk(i_clk), .i_we(slot_we), .i_waddr(slot_waddr), .i_wdata(slot_wdata),
        .i_raddr(slot_raddr), .o_rdata(slot_rdata)
    );
    mcbf_ram #(.Width(32), .Depth(WordDepth)) u_word_ram (
        .i_clk(i_clk), .i_we(word_we), .i_waddr(word_waddr), .i_wdata(word_wdata),
        .i_raddr(word_raddr), .o_rdata(word_rdata)
    );

    logic accept;
    assign o_in_stall  = (r_state != S_IDLE) || r_clear || r_out_valid;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // request decode
    logic            ch_in_range;
    logic [ChW-1:0]  ch_idx;
    logic            ch_ok;
    assign ch_in_range = ({24'd0, r_req.channel} < 32'(MaxChannels));
    assign ch_idx      = r_req.channel[ChW-1:0];
    assign ch_ok       = ch_in_range && r_open[ch_idx];

    // lowest free slot
    logic            free_any;
    logic [ChW-1:0]  free_idx;
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = MaxChannels - 1; i >= 0; i--) begin
            if (!r_open[i]) begin
                free_any = 1'b1;
                free_idx = ChW'(i);
            end
        end
    end

    logic [CntW-1:0] sat_limit;
    assign sat_limit = (r_req.req_limit > 32'(QueueDepth)) ? CntW'(QueueDepth)
                                                           : CntW'(r_req.req_limit);

    logic [ChW-1:0] walk_idx;
    assign walk_idx = r_idx[ChW-1:0];
    logic walk_last;
    assign walk_last = (r_idx == (ChW+1)'(MaxChannels - 1));

    // queue position wraps at the queue depth
    logic [PosW-1:0] tail_pos;
    assign tail_pos = slot_rdata.head + slot_rdata.count[PosW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_req.action == ACT_BROADCAST) begin
                    n_state = S_BC_READ;
                end else if (r_req.action == ACT_RECV && ch_ok) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_BC_READ:  n_state = S_BC_CHECK;
            S_BC_CHECK: begin
                if (walk_last) begin
                    n_state = (r_open == '0 || n_full_seen) ? S_IDLE : S_BC_WRITE;
                end
            end
            S_BC_WRITE: begin
                if (walk_last) begin
                    n_state = S_IDLE;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_idx       = r_idx;
        n_clear     = r_clear;
        n_full_seen = r_full_seen;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        slot_raddr  = ch_idx;
        slot_we     = 1'b0;
        slot_waddr  = ch_idx;
        slot_wdata  = slot_rdata;
        word_we     = 1'b0;
        word_waddr  = {ch_idx, tail_pos};
        word_wdata  = r_req.data_in;
        word_raddr  = {ch_idx, slot_rdata.head};

        if (r_clear) begin
            slot_we    = 1'b1;
            slot_waddr = walk_idx;
            slot_wdata = '0;
            n_idx      = r_idx + 1'b1;
            if (walk_last) begin
                n_clear = 1'b0;
                n_idx   = '0;
            end
        end

        case (r_state)
            S_IDLE: begin
                n_idx       = r_clear ? n_idx : '0;
                n_full_seen = 1'b0;
                slot_raddr  = i_in_item.channel[ChW-1:0];
            end
            S_EXEC: begin
                n_out = '{status: ST_NO_CHANNEL, opened_channel: 3'd0, data_out: 32'd0};
                case (r_req.action)
                    ACT_OPEN: begin
                        n_out_valid = 1'b1;
                        if (free_any) begin
                            slot_we    = 1'b1;
                            slot_waddr = free_idx;
                            slot_wdata = '{open: 1'b1, limit: sat_limit,
                                           count: '0, head: '0};
                            n_out.status = ST_OK;
                            n_out.opened_channel = 3'(free_idx);
                        end else begin
                            n_out.status = ST_NO_FREE_SLOT;
                        end
                    end
                    ACT_CLOSE: begin
                        n_out_valid = 1'b1;
                        if (ch_ok) begin
                            slot_we      = 1'b1;
                            slot_wdata   = '0;
                            n_out.status = ST_OK;
                        end
                    end
                    ACT_SEND: begin
                        n_out_valid = 1'b1;
                        if (ch_ok) begin
                            if (slot_rdata.count < slot_rdata.limit) begin
                                word_we          = 1'b1;
                                slot_we          = 1'b1;
                                slot_wdata.count = slot_rdata.count + 1'b1;
                                n_out.status     = ST_OK;
                            end else begin
                                n_out.status = ST_WOULD_BLOCK;
                            end
                        end
                    end
                    ACT_RECV: begin
                        if (ch_ok) begin
                            if (slot_rdata.count != '0) begin
                                slot_we          = 1'b1;
                                slot_wdata.count = slot_rdata.count - 1'b1;
                                slot_wdata.head  = slot_rdata.head + 1'b1;
                                n_out.status     = ST_OK;
                            end else begin
                                n_out.status = ST_WOULD_BLOCK;
                            end
                        end else begin
                            n_out_valid = 1'b1;
                        end
                    end
                    ACT_BROADCAST: begin
                        slot_raddr = '0;
                        n_idx      = '0;
                    end
                    default: n_out_valid = 1'b1;
                endcase
            end
            S_DONE: begin
                // word read issued in exec lands now
                n_out_valid = 1'b1;
                if (r_out.status == ST_OK) begin
                    n_out.data_out = word_rdata;
                end
            end
            S_BC_READ: begin
                // first slot read, lands in the first check cycle
                slot_raddr = walk_idx;
            end
            S_BC_CHECK: begin
                if (r_open[walk_idx] && slot_rdata.count >= slot_rdata.limit) begin
                    n_full_seen = 1'b1;
                end
                slot_raddr = walk_idx + 1'b1;
                n_idx      = r_idx + 1'b1;
                if (walk_last) begin
                    n_idx      = '0;
                    slot_raddr = '0;
                    if (r_open == '0 || n_full_seen) begin
                        n_out_valid  = 1'b1;
                        n_out = '{status: (r_open == '0) ? ST_NO_CHANNEL : ST_WOULD_BLOCK,
                                  opened_channel: 3'd0, data_out: 32'd0};
                    end
                end
            end
            S_BC_WRITE: begin
                // read of next slot was issued last cycle
                slot_raddr = walk_idx + 1'b1;
                slot_waddr = walk_idx;
                word_waddr = {walk_idx, tail_pos};
                if (r_open[walk_idx]) begin
                    slot_we          = 1'b1;
                    slot_wdata.count = slot_rdata.count + 1'b1;
                    word_we          = 1'b1;
                end
                n_idx = r_idx + 1'b1;
                if (walk_last) begin
                    n_idx       = '0;
                    n_out_valid = 1'b1;
                    n_out = '{status: ST_OK, opened_channel: 3'd0, data_out: 32'd0};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_open      <= '0;
            r_idx       <= '0;
            r_clear     <= 1'b1;
            r_full_seen <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_clear     <= n_clear;
            r_full_seen <= n_full_seen;
            r_out_valid <= n_out_valid;
            if (r_state == S_EXEC && r_req.action == ACT_OPEN && free_any) begin
                r_open[free_idx] <= 1'b1;
            end
            if (r_state == S_EXEC && r_req.action == ACT_CLOSE && ch_ok) begin
                r_open[ch_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (accept) begin
            r_req <= i_in_item;
        end
    end
endmodule
